// ===== src/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, status codes and the divider pipeline record for the
// quaternion vector rotation block.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int VEC_WIDTH  = 24;
    localparam int QUAT_WIDTH = 16;

    localparam int P_W   = 2 * QUAT_WIDTH;
    localparam int C_W   = 2 * QUAT_WIDTH + 2;
    localparam int N_W   = 2 * QUAT_WIDTH + 1;
    localparam int M_W   = C_W + VEC_WIDTH;
    localparam int S_W   = M_W + 2;
    localparam int REM_W = 2 * QUAT_WIDTH + VEC_WIDTH;

    localparam int FRONT_STAGES = 4;
    localparam int LATENCY      = FRONT_STAGES + VEC_WIDTH + 1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic                             valid;
        logic                             zero;
        logic [2:0]                       neg;
        logic [N_W-1:0]                   n;
        logic [2:0][REM_W-1:0]            rem;
        logic [2:0][VEC_WIDTH-1:0]        quot;
    } div_t;

endpackage

// ===== src/qvr_front.sv =====
// ----------------------------------------------------------------------------
// qvr_front
// Four register stages: quaternion products, scaled rotation matrix and norm,
// matrix times vector products, row sums with sign and magnitude.
// ----------------------------------------------------------------------------
module qvr_front
    import qvr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    input  logic signed [VEC_WIDTH-1:0]  vec_x,
    input  logic signed [VEC_WIDTH-1:0]  vec_y,
    input  logic signed [VEC_WIDTH-1:0]  vec_z,
    output div_t                        out
);

    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [P_W-1:0]      p_reg [10];
    logic signed [P_W-1:0]      p_next [10];
    logic signed [VEC_WIDTH-1:0] vec1_reg [3];
    logic signed [VEC_WIDTH-1:0] vec2_reg [3];
    logic signed [C_W-1:0]      c_reg [9];
    logic signed [C_W-1:0]      c_next [9];
    logic [N_W-1:0]             n2_reg, n3_reg;
    logic [N_W-1:0]             n_next;
    logic signed [M_W-1:0]      m_reg [9];
    logic signed [M_W-1:0]      m_next [9];
    div_t                       out_reg;
    div_t                       out_next;
    logic signed [S_W-1:0]      sum [3];
    logic [S_W-1:0]             mag [3];

    // Product order: ww xx yy zz xy wz xz wy yz wx.
    always_comb
    begin
        p_next[0] = quat_w * quat_w;
        p_next[1] = quat_x * quat_x;
        p_next[2] = quat_y * quat_y;
        p_next[3] = quat_z * quat_z;
        p_next[4] = quat_x * quat_y;
        p_next[5] = quat_w * quat_z;
        p_next[6] = quat_x * quat_z;
        p_next[7] = quat_w * quat_y;
        p_next[8] = quat_y * quat_z;
        p_next[9] = quat_w * quat_x;
    end

    always_comb
    begin
        c_next[0] = C_W'(p_reg[0]) + C_W'(p_reg[1]) - C_W'(p_reg[2]) - C_W'(p_reg[3]);
        c_next[1] = (C_W'(p_reg[4]) - C_W'(p_reg[5])) <<< 1;
        c_next[2] = (C_W'(p_reg[6]) + C_W'(p_reg[7])) <<< 1;
        c_next[3] = (C_W'(p_reg[4]) + C_W'(p_reg[5])) <<< 1;
        c_next[4] = C_W'(p_reg[0]) - C_W'(p_reg[1]) + C_W'(p_reg[2]) - C_W'(p_reg[3]);
        c_next[5] = (C_W'(p_reg[8]) - C_W'(p_reg[9])) <<< 1;
        c_next[6] = (C_W'(p_reg[6]) - C_W'(p_reg[7])) <<< 1;
        c_next[7] = (C_W'(p_reg[8]) + C_W'(p_reg[9])) <<< 1;
        c_next[8] = C_W'(p_reg[0]) - C_W'(p_reg[1]) - C_W'(p_reg[2]) + C_W'(p_reg[3]);
        n_next    = N_W'($unsigned(p_reg[0])) + N_W'($unsigned(p_reg[1]))
                  + N_W'($unsigned(p_reg[2])) + N_W'($unsigned(p_reg[3]));
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m_next[k] = M_W'(c_reg[k]) * M_W'(vec2_reg[k % 3]);
        end
    end

    always_comb
    begin
        out_next       = '0;
        out_next.valid = v3_reg;
        out_next.zero  = (n3_reg == '0);
        out_next.n     = n3_reg;
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = S_W'(m_reg[3*r]) + S_W'(m_reg[3*r+1]) + S_W'(m_reg[3*r+2]);
            mag[r] = sum[r][S_W-1] ? $unsigned(-sum[r]) : $unsigned(sum[r]);
            out_next.neg[r] = sum[r][S_W-1];
            out_next.rem[r] = mag[r][REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= out_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        vec1_reg[0] <= vec_x;
        vec1_reg[1] <= vec_y;
        vec1_reg[2] <= vec_z;
        c_reg       <= c_next;
        n2_reg      <= n_next;
        vec2_reg    <= vec1_reg;
        m_reg       <= m_next;
        n3_reg      <= n2_reg;
        out_reg     <= out_next;
    end

    always_comb
    begin
        out       = out_reg;
        out.valid = v4_reg;
    end

endmodule

// ===== src/qvr_divider.sv =====
// ----------------------------------------------------------------------------
// qvr_divider
// Restoring divider, one quotient bit per register stage, three rows in
// parallel. The quotient magnitude is below two to the vector width.
// ----------------------------------------------------------------------------
module qvr_divider
    import qvr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  div_t in,
    output div_t out
);

    div_t stage_reg [VEC_WIDTH+1];

    always_comb
    begin
        stage_reg[0] = in;
    end

    for (genvar i = 0; i < VEC_WIDTH; i++)
    begin : g_stage
        localparam int B = VEC_WIDTH - 1 - i;
        div_t            step_next;
        logic [REM_W-1:0] trial;

        always_comb
        begin
            step_next = stage_reg[i];
            trial     = REM_W'(stage_reg[i].n) << B;
            for (int r = 0; r < 3; r++)
            begin
                if (stage_reg[i].rem[r] >= trial)
                begin
                    step_next.rem[r]  = stage_reg[i].rem[r] - trial;
                    step_next.quot[r] = {stage_reg[i].quot[r][VEC_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    step_next.quot[r] = {stage_reg[i].quot[r][VEC_WIDTH-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[i+1] <= '0;
            end
            else
            begin
                stage_reg[i+1] <= step_next;
            end
        end
    end

    assign out = stage_reg[VEC_WIDTH];

endmodule

// ===== src/qvr_round.sv =====
// ----------------------------------------------------------------------------
// qvr_round
// Rounds each quotient to nearest with ties away from zero, saturates,
// restores the sign and registers the result and its status.
// ----------------------------------------------------------------------------
module qvr_round
    import qvr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  div_t                        in,
    output logic                        done,
    output logic signed [VEC_WIDTH-1:0] rot_x,
    output logic signed [VEC_WIDTH-1:0] rot_y,
    output logic signed [VEC_WIDTH-1:0] rot_z,
    output logic [1:0]                  status
);

    logic                 done_reg;
    logic [VEC_WIDTH-1:0] rot_reg [3];
    logic [VEC_WIDTH-1:0] rot_next [3];
    logic [1:0]           status_reg, status_next;
    logic [VEC_WIDTH:0]   qr [3];
    logic [VEC_WIDTH:0]   lim [3];
    logic [VEC_WIDTH:0]   mag [3];
    logic [2:0]           sat;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            qr[r]  = (VEC_WIDTH+1)'(in.quot[r])
                   + (VEC_WIDTH+1)'(((REM_W+1)'(in.rem[r]) << 1) >= (REM_W+1)'(in.n));
            lim[r] = in.neg[r] ? ((VEC_WIDTH+1)'(1) << (VEC_WIDTH-1))
                               : ((VEC_WIDTH+1)'(1) << (VEC_WIDTH-1)) - 1'b1;
            sat[r] = qr[r] > lim[r];
            mag[r] = sat[r] ? lim[r] : qr[r];
            rot_next[r] = in.neg[r] ? VEC_WIDTH'(-mag[r]) : VEC_WIDTH'(mag[r]);
            if (in.zero)
            begin
                rot_next[r] = '0;
            end
        end
        if (in.zero)
        begin
            status_next = ST_ZERO;
        end
        else if (sat != 3'b000)
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg    <= rot_next;
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign rot_x  = rot_reg[0];
    assign rot_y  = rot_reg[1];
    assign rot_z  = rot_reg[2];
    assign status = status_reg;

endmodule

// ===== src/quaternion_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a vector by q * (0,v) * q^-1 with integer arithmetic and a rounded division.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy is always
// low. Each request produces one result, marked by done, after it has passed
// the pipeline: four stages form the products, the rotation matrix and the row sums,
// 24 stages of a restoring divider give one quotient bit each, and one stage
// rounds and saturates. The receiver cannot stall, and none is needed, since
// results leave in the order and at the rate requests arrive.
module quaternion_vector_rotation
    import qvr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    input  logic signed [VEC_WIDTH-1:0]  vec_x,
    input  logic signed [VEC_WIDTH-1:0]  vec_y,
    input  logic signed [VEC_WIDTH-1:0]  vec_z,
    output logic                         done,
    output logic signed [VEC_WIDTH-1:0]  rot_x,
    output logic signed [VEC_WIDTH-1:0]  rot_y,
    output logic signed [VEC_WIDTH-1:0]  rot_z,
    output logic [1:0]                   status
);

    div_t front_out;
    div_t div_out;

    assign busy = 1'b0;

    qvr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .quat_w   (quat_w),
        .quat_x   (quat_x),
        .quat_y   (quat_y),
        .quat_z   (quat_z),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .out      (front_out)
    );

    qvr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (front_out),
        .out   (div_out)
    );

    qvr_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .in     (div_out),
        .done   (done),
        .rot_x  (rot_x),
        .rot_y  (rot_y),
        .rot_z  (rot_z),
        .status (status)
    );

endmodule

// ===== src/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks on request timing and result status.
// ----------------------------------------------------------------------------
module qvr_checker
    import qvr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [VEC_WIDTH-1:0] rot_x,
    input logic [VEC_WIDTH-1:0] rot_y,
    input logic [VEC_WIDTH-1:0] rot_z,
    input logic [1:0]           status
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_SAT || status == ST_ZERO))
        else $error("bad status code");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_ZERO) |-> (rot_x == '0 && rot_y == '0 && rot_z == '0))
        else $error("zero quaternion gave nonzero result");

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .rot_x  (rot_x),
    .rot_y  (rot_y),
    .rot_z  (rot_z),
    .status (status)
);
